// ----- rtl/core/mss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the multi-stack shared store
// Sizes, slot index encoding, operation and status codes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mss_pkg;

   // Build sizes
   localparam int NUM_STACKS  = 4;
   localparam int CAPACITY    = 16;

   // Fixed field widths
   localparam int STACK_ID_W  = 2;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;

   // Stacks reachable through the stack id field
   localparam int STACK_COUNT = (NUM_STACKS < (1 << STACK_ID_W)) ?
                                NUM_STACKS : (1 << STACK_ID_W);
   localparam int STACK_IDX_W = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;

   // Slot index holds every slot plus the null code
   localparam int SLOT_W      = $clog2(CAPACITY + 1);
   localparam int ADDR_W      = $clog2(CAPACITY);

   typedef logic [SLOT_W-1:0] slot_type;

   localparam slot_type NULL_SLOT = slot_type'(CAPACITY);

   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_POP  = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_EXEC
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch request, issue reads
      logic commit;    // update lists, load response
   } mss_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // response register can take a new result
   } mss_stat_type;

endpackage : mss_pkg
`default_nettype wire

// ----- rtl/core/mss_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mss_ctrl: operation sequencer
// Accepts one request, lets the registered reads complete in the execute
// state, then commits once the response register is free.
// ----------------------------------------------------------------------------
module mss_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  mss_pkg::mss_stat_type stat,
   output mss_pkg::mss_cmd_type  cmd
);
   import mss_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

endmodule : mss_ctrl
`default_nettype wire

// ----- rtl/core/mss_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mss_datapath: slot store, link list, stack tops and response register
// Reads the target slot's link and data on capture, applies the push or
// pop on commit and holds the result until the response transfer.
// ----------------------------------------------------------------------------
module mss_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  mss_pkg::mss_cmd_type                  cmd,
   output mss_pkg::mss_stat_type                 stat,
   input  wire                                   req_action,
   input  wire [mss_pkg::STACK_ID_W-1:0]         req_stack_id,
   input  wire signed [mss_pkg::DATA_W-1:0]      req_push_value,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [mss_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [mss_pkg::DATA_W-1:0]     rsp_pop_value
);
   import mss_pkg::*;

   // Storage
   logic [DATA_W-1:0]   data_mem [CAPACITY];
   slot_type            link_ff [CAPACITY];
   logic [CAPACITY-1:0] link_vld_ff;
   slot_type            top_ff [STACK_COUNT];
   slot_type            free_head_ff;

   // Latched request and read data
   logic                    action_ff;
   logic [STACK_IDX_W-1:0]  sid_ff;
   logic                    id_ok_ff;
   slot_type                slot_ff;
   logic                    slot_ok_ff;
   logic [DATA_W-1:0]       value_ff;
   slot_type                link_rd_ff;
   logic [DATA_W-1:0]       data_rd_ff;

   // Response register
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [DATA_W-1:0]       rsp_value_ff;

   logic [STACK_IDX_W-1:0]  req_idx;
   logic                    req_id_ok;
   slot_type                req_slot;
   logic [ADDR_W-1:0]       rd_addr;
   slot_type                link_rd;
   logic [ADDR_W-1:0]       wr_addr;
   logic                    push_ok;
   logic                    pop_ok;

   // Select the target slot: free head for a push, stack top for a pop
   always_comb begin
      req_idx   = req_stack_id[STACK_IDX_W-1:0];
      req_id_ok = (int'(req_stack_id) < STACK_COUNT);
      req_slot  = (req_action == ACT_POP) ? top_ff[req_idx] : free_head_ff;
      rd_addr   = req_slot[ADDR_W-1:0];
      // Unwritten links keep their reset chain: next slot, last one null
      link_rd   = link_vld_ff[rd_addr] ? link_ff[rd_addr] :
                  slot_type'(rd_addr) + slot_type'(1);
   end

   assign wr_addr = slot_ff[ADDR_W-1:0];
   assign push_ok = (action_ff == ACT_PUSH) && id_ok_ff && slot_ok_ff;
   assign pop_ok  = (action_ff == ACT_POP) && id_ok_ff && slot_ok_ff;

   // Latch the request and the link at the target slot
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_action;
         sid_ff     <= req_idx;
         id_ok_ff   <= req_id_ok;
         slot_ff    <= req_slot;
         slot_ok_ff <= (req_slot < NULL_SLOT);
         value_ff   <= req_push_value;
         link_rd_ff <= link_rd;
      end
   end

   // Data store: registered read on capture, write on a pushing commit
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         data_rd_ff <= data_mem[rd_addr];
      end
      if (cmd.commit && push_ok) begin
         data_mem[wr_addr] <= value_ff;
      end
   end

   // Link store payload
   always_ff @(posedge clock) begin
      if (cmd.commit && push_ok) begin
         link_ff[wr_addr] <= top_ff[sid_ff];
      end else if (cmd.commit && pop_ok) begin
         link_ff[wr_addr] <= free_head_ff;
      end
   end

   // List heads and link valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff  <= '0;
         free_head_ff <= '0;
         for (int i = 0; i < STACK_COUNT; i++) begin
            top_ff[i] <= NULL_SLOT;
         end
      end else if (cmd.commit) begin
         if (push_ok) begin
            free_head_ff         <= link_rd_ff;
            top_ff[sid_ff]       <= slot_ff;
            link_vld_ff[wr_addr] <= 1'b1;
         end else if (pop_ok) begin
            top_ff[sid_ff]       <= link_rd_ff;
            free_head_ff         <= slot_ff;
            link_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Response valid: set on commit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (push_ok || pop_ok) begin
            rsp_status_ff <= ST_OK;
         end else if (action_ff == ACT_PUSH) begin
            rsp_status_ff <= ST_OVERFLOW;
         end else begin
            rsp_status_ff <= ST_UNDERFLOW;
         end
         rsp_value_ff <= pop_ok ? data_rd_ff : '0;
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pop_value  = rsp_value_ff;

   // Checks
   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not load the response register");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("commit overwrote an untaken response");

   a_push_moves_head: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && push_ok |=> free_head_ff == $past(link_rd_ff))
      else $error("push did not advance the free list");

   a_pop_frees_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && pop_ok |=> free_head_ff == $past(slot_ff))
      else $error("pop did not return its slot to the free list");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0)
      else $error("failed operation carries a nonzero value");

endmodule : mss_datapath
`default_nettype wire

// ----- rtl/core/multi_stack_shared_store_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stack_shared_store_core: several stacks sharing one slot store
// Push takes the free-list head and links it above the chosen stack's top;
// pop unlinks the top slot, returns it to the free list and gives its value.
//
//   channel  ports                                   direction
//   req      req_valid/ready, action, stack_id,      in
//            push_value
//   rsp      rsp_valid/ready, status, pop_value      out
//
// Each request is accepted in the idle state, which reads the target slot's
// link and data (one registered read per store); the execute state commits.
// A new request is not accepted until the previous one has committed.
// The commit waits while the response register holds an untaken result.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_stack_shared_store_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_action,
   input  wire [mss_pkg::STACK_ID_W-1:0]      req_stack_id,
   input  wire signed [mss_pkg::DATA_W-1:0]   req_push_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [mss_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [mss_pkg::DATA_W-1:0]  rsp_pop_value
);
   import mss_pkg::*;

   mss_cmd_type  cmd;
   mss_stat_type stat;

   // Sequencer
   mss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and response
   mss_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_stack_id   (req_stack_id),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value)
   );

endmodule : multi_stack_shared_store_core
`default_nettype wire
